// ----- src/mbcg_pkg.sv -----
// Shared types and constants for the center-of-gravity accumulator.
package mbcg_pkg;

   localparam int unsigned MASS_W    = 20;
   localparam int unsigned STATION_W = 16;
   localparam int unsigned SUM_W     = 24;
   localparam int unsigned MOMENT_W  = 40;
   localparam int unsigned PROD_W    = MASS_W + 1 + STATION_W;
   localparam int unsigned STATUS_W  = 2;

   // Quotient magnitude never exceeds 2^15, so 16 restoring steps suffice.
   localparam int unsigned QUOT_W    = 16;
   localparam int unsigned STEP_W    = $clog2(QUOT_W);

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_MASS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_CHECK,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic                done;
      logic [QUOT_W-1:0]   quotient;
   } div_result_type;

endpackage

// ----- src/mass_balance_cg_accumulator_unit.sv -----
// Top level: weight-and-balance accumulator with serial center-of-gravity divide.
//
//  channel | ports                                    | handshake
//  --------+------------------------------------------+------------------------------
//  input   | req_load_mass, req_load_station,         | start && !busy takes a word
//          | req_last_load                            |
//  result  | rsp_total_mass, rsp_total_moment,        | rsp_valid high one cycle,
//          | rsp_cg_station, rsp_status               | taken at the edge ending it
//
// A load that is not last keeps busy high through the accumulate state, so the next load waits.
// A last load then passes through a check state; with nonzero mass and no overflow the restoring
// divider then runs to done, and the result strobe is registered after that.
// The product is formed in the accept cycle by one 21x16 multiplier; the adders
// update the sums in the next cycle. Synchronous reset clears the sums and the sequencer.
// The receiver cannot stall: each result is shown for exactly one cycle.
module mass_balance_cg_accumulator_unit #(
   parameter int unsigned MAX_LOADS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [mbcg_pkg::MASS_W-1:0]            req_load_mass,
   input  logic signed [mbcg_pkg::STATION_W-1:0]  req_load_station,
   input  logic                                   req_last_load,
   output logic                                   rsp_valid,
   output logic [mbcg_pkg::SUM_W-1:0]             rsp_total_mass,
   output logic signed [mbcg_pkg::MOMENT_W-1:0]   rsp_total_moment,
   output logic signed [mbcg_pkg::STATION_W-1:0]  rsp_cg_station,
   output logic [mbcg_pkg::STATUS_W-1:0]          rsp_status
);

   localparam int unsigned CNT_W = $clog2(MAX_LOADS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LOADS);

   mbcg_pkg::state_type state_ff;
   mbcg_pkg::state_type state_in;

   logic [mbcg_pkg::SUM_W-1:0]           mass_sum_ff;
   logic signed [mbcg_pkg::MOMENT_W-1:0] moment_sum_ff;
   logic [CNT_W-1:0]                     load_count_ff;
   logic                                 overflow_ff;

   logic signed [mbcg_pkg::PROD_W-1:0]   prod_ff;
   logic [mbcg_pkg::MASS_W-1:0]          mass_ff;
   logic                                 last_ff;
   logic                                 skip_ff;
   logic                                 neg_ff;

   logic                                 rsp_valid_ff;
   logic [mbcg_pkg::SUM_W-1:0]           rsp_mass_ff;
   logic signed [mbcg_pkg::MOMENT_W-1:0] rsp_moment_ff;
   logic signed [mbcg_pkg::STATION_W-1:0] rsp_cg_ff;
   logic [mbcg_pkg::STATUS_W-1:0]        rsp_status_ff;

   logic                                 accept;
   logic                                 do_acc;
   logic                                 emit_early;
   logic                                 div_start;
   logic                                 emit_div;
   logic [mbcg_pkg::MOMENT_W-1:0]        moment_mag;
   logic [mbcg_pkg::STATION_W-1:0]       cg_value;
   mbcg_pkg::div_result_type             div_res;

   assign accept = start && !busy;
   assign busy   = (state_ff != mbcg_pkg::ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbcg_pkg::ST_IDLE:  if (accept) state_in = mbcg_pkg::ST_ACC;
         mbcg_pkg::ST_ACC:   state_in = last_ff ? mbcg_pkg::ST_CHECK : mbcg_pkg::ST_IDLE;
         mbcg_pkg::ST_CHECK: begin
            if (overflow_ff || mass_sum_ff == '0) begin
               state_in = mbcg_pkg::ST_IDLE;
            end else begin
               state_in = mbcg_pkg::ST_DIV;
            end
         end
         mbcg_pkg::ST_DIV:   if (div_res.done) state_in = mbcg_pkg::ST_IDLE;
         default:            state_in = mbcg_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      do_acc     = 1'b0;
      emit_early = 1'b0;
      div_start  = 1'b0;
      emit_div   = 1'b0;
      unique case (state_ff)
         mbcg_pkg::ST_IDLE:  ;
         mbcg_pkg::ST_ACC:   do_acc = 1'b1;
         mbcg_pkg::ST_CHECK: begin
            emit_early = overflow_ff || (mass_sum_ff == '0);
            div_start  = !emit_early;
         end
         mbcg_pkg::ST_DIV:   emit_div = div_res.done;
         default:            ;
      endcase
   end

   assign moment_mag = moment_sum_ff[mbcg_pkg::MOMENT_W-1] ? 
                       mbcg_pkg::MOMENT_W'(-moment_sum_ff) : moment_sum_ff;
   assign cg_value   = neg_ff ? mbcg_pkg::STATION_W'(-div_res.quotient) : div_res.quotient;

   mbcg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (moment_mag),
      .divisor  (mass_sum_ff),
      .result   (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mbcg_pkg::ST_IDLE;
         mass_sum_ff   <= '0;
         moment_sum_ff <= '0;
         load_count_ff <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit_early || emit_div;
         if (do_acc) begin
            if (skip_ff) begin
               overflow_ff <= 1'b1;
            end else begin
               mass_sum_ff   <= mass_sum_ff + mbcg_pkg::SUM_W'(mass_ff);
               moment_sum_ff <= moment_sum_ff + mbcg_pkg::MOMENT_W'(prod_ff);
               load_count_ff <= load_count_ff + 1'b1;
            end
         end
         // Clear the run once its result is out.
         if (emit_early || emit_div) begin
            mass_sum_ff   <= '0;
            moment_sum_ff <= '0;
            load_count_ff <= '0;
            overflow_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff <= $signed({1'b0, req_load_mass}) * req_load_station;
         mass_ff <= req_load_mass;
         last_ff <= req_last_load;
         skip_ff <= (load_count_ff >= MAX_CNT);
      end
      if (div_start) begin
         neg_ff <= moment_sum_ff[mbcg_pkg::MOMENT_W-1];
      end
      if (emit_early) begin
         rsp_cg_ff <= '0;
         if (overflow_ff) begin
            rsp_mass_ff   <= '0;
            rsp_moment_ff <= '0;
            rsp_status_ff <= mbcg_pkg::STATUS_OVERFLOW;
         end else begin
            rsp_mass_ff   <= '0;
            rsp_moment_ff <= moment_sum_ff;
            rsp_status_ff <= mbcg_pkg::STATUS_ZERO_MASS;
         end
      end else if (emit_div) begin
         rsp_mass_ff   <= mass_sum_ff;
         rsp_moment_ff <= moment_sum_ff;
         rsp_cg_ff     <= cg_value;
         rsp_status_ff <= mbcg_pkg::STATUS_OK;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_mass   = rsp_mass_ff;
   assign rsp_total_moment = rsp_moment_ff;
   assign rsp_cg_station   = rsp_cg_ff;
   assign rsp_status       = rsp_status_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after taking a word");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == mbcg_pkg::ST_DIV)
      else $error("divider finished outside the divide state");

   a_ok_has_mass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mbcg_pkg::STATUS_OK |-> rsp_total_mass != '0)
      else $error("ok status reported with zero total mass");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= MAX_CNT)
      else $error("load count beyond its limit");

endmodule

// ----- src/mbcg_div.sv -----
// Bit-serial restoring divider: unsigned magnitude by unsigned mass, one quotient bit a cycle.
module mbcg_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mbcg_pkg::MOMENT_W-1:0]     dividend,
   input  logic [mbcg_pkg::SUM_W-1:0]        divisor,
   output mbcg_pkg::div_result_type          result
);

   logic [mbcg_pkg::SUM_W-1:0]    rem_ff;
   logic [mbcg_pkg::SUM_W-1:0]    rem_in;
   logic [mbcg_pkg::QUOT_W-1:0]   shift_ff;
   logic [mbcg_pkg::QUOT_W-1:0]   shift_in;
   logic [mbcg_pkg::SUM_W-1:0]    dvsr_ff;
   logic [mbcg_pkg::STEP_W-1:0]   step_ff;
   logic [mbcg_pkg::STEP_W-1:0]   step_in;
   logic                          run_ff;
   logic                          run_in;
   logic                          done_ff;
   logic                          done_in;
   logic [mbcg_pkg::SUM_W:0]      trial;
   logic                          qbit;

   // Trial subtract of the divisor from the partial remainder with the next bit shifted in.
   always_comb begin
      trial = {rem_ff, shift_ff[mbcg_pkg::QUOT_W-1]} - {1'b0, dvsr_ff};
      qbit  = !trial[mbcg_pkg::SUM_W];
   end

   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         // Upper bits are already below the divisor, so they seed the remainder.
         rem_in   = dividend[mbcg_pkg::MOMENT_W-1:mbcg_pkg::QUOT_W];
         shift_in = dividend[mbcg_pkg::QUOT_W-1:0];
         step_in  = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         rem_in   = qbit ? trial[mbcg_pkg::SUM_W-1:0]
                         : {rem_ff[mbcg_pkg::SUM_W-2:0], shift_ff[mbcg_pkg::QUOT_W-1]};
         shift_in = {shift_ff[mbcg_pkg::QUOT_W-2:0], qbit};
         step_in  = step_ff + 1'b1;
         if (step_ff == mbcg_pkg::STEP_W'(mbcg_pkg::QUOT_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      if (start) begin
         dvsr_ff <= divisor;
      end
   end

   assign result.done     = done_ff;
   assign result.quotient = shift_ff;

endmodule
